### rtl/core/kwl_pkg.sv
// shared types, constants and lexing functions for the keyword token lexer
package kwl_pkg;

   localparam int MAX_TEXT_BYTES = 65536;
   localparam int KEYWORD_BYTES = 8;
   localparam int POS_LIMIT = (MAX_TEXT_BYTES < 65535) ? MAX_TEXT_BYTES : 65535;
   localparam int QUEUE_DEPTH = 2;
   localparam int MAX_TOKENS = 3;

   localparam logic [5:0] K_ID = 6'd16;
   localparam logic [5:0] K_NUM = 6'd17;
   localparam logic [5:0] K_OP_NE = 6'd18;
   localparam logic [5:0] K_OP_LE = 6'd19;
   localparam logic [5:0] K_OP_GE = 6'd20;
   localparam logic [5:0] K_OP_ARROW = 6'd21;
   localparam logic [5:0] K_OP_EQ = 6'd22;
   localparam logic [5:0] K_PUNCT = 6'd23;
   localparam logic [5:0] K_ERROR = 6'd42;
   localparam logic [5:0] K_END = 6'd43;
   localparam logic [5:0] K_NONE = 6'd63;

   localparam logic [63:0] KW_TEXT [16] = '{
      {"int", 40'd0}, {"struct", 16'd0}, {"nil", 40'd0}, {"break", 24'd0},
      "continue", {"return", 16'd0}, {"if", 48'd0}, {"else", 32'd0},
      {"while", 24'd0}, {"new", 40'd0}, {"let", 40'd0}, {"extern", 16'd0},
      {"fn", 48'd0}, {"and", 40'd0}, {"or", 48'd0}, {"not", 40'd0}
   };
   localparam logic [3:0] KW_LEN [16] = '{
      4'd3, 4'd6, 4'd3, 4'd5, 4'd8, 4'd6, 4'd2, 4'd4,
      4'd5, 4'd3, 4'd3, 4'd6, 4'd2, 4'd3, 4'd2, 4'd3
   };

   typedef enum logic [3:0] {
      M_IDLE, M_IDENT, M_NUMBER, M_HELD, M_ERROR, M_ERRBANG, M_LINE, M_BLOCK, M_BLOCKSTAR
   } scan_mode_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_last;
   } req_word_type;

   typedef struct packed {
      logic [5:0]  token_kind;
      logic [15:0] start_pos;
      logic [15:0] end_pos;
      logic        final_item;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]            count;
      rsp_word_type [2:0]    tok;
   } bundle_type;

   typedef struct packed {
      scan_mode_type   mode;
      logic [15:0]     tstart;
      logic [3:0]      wlen;
      logic [7:0]      held;
      logic [7:0][7:0] prefix;
   } lex_state_type;

   typedef struct packed {
      lex_state_type st;
      logic          redo;
      logic [1:0]    n;
      rsp_word_type  tok0;
      rsp_word_type  tok1;
   } step_out_type;

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_holdable(input logic [7:0] c);
      return c == "!" || c == "<" || c == ">" || c == "-" || c == "=" || c == "/";
   endfunction

   function automatic logic [5:0] punct_kind(input logic [7:0] c);
      logic [5:0] k;
      case (c)
         ":": k = K_PUNCT + 6'd0;
         ";": k = K_PUNCT + 6'd1;
         ",": k = K_PUNCT + 6'd2;
         "&": k = K_PUNCT + 6'd3;
         "+": k = K_PUNCT + 6'd4;
         "-": k = K_PUNCT + 6'd5;
         "*": k = K_PUNCT + 6'd6;
         "/": k = K_PUNCT + 6'd7;
         "<": k = K_PUNCT + 6'd8;
         ">": k = K_PUNCT + 6'd9;
         ".": k = K_PUNCT + 6'd10;
         "=": k = K_PUNCT + 6'd11;
         "(": k = K_PUNCT + 6'd12;
         ")": k = K_PUNCT + 6'd13;
         "[": k = K_PUNCT + 6'd14;
         "]": k = K_PUNCT + 6'd15;
         "{": k = K_PUNCT + 6'd16;
         "}": k = K_PUNCT + 6'd17;
         "?": k = K_PUNCT + 6'd18;
         default: k = K_NONE;
      endcase
      return k;
   endfunction

   function automatic logic [5:0] op_kind(input logic [7:0] a, input logic [7:0] b);
      logic [5:0] k;
      k = K_NONE;
      if (b == "=") begin
         case (a)
            "!": k = K_OP_NE;
            "<": k = K_OP_LE;
            ">": k = K_OP_GE;
            "=": k = K_OP_EQ;
            default: k = K_NONE;
         endcase
      end else if (a == "-" && b == ">") begin
         k = K_OP_ARROW;
      end
      return k;
   endfunction

   function automatic logic [5:0] word_kind(input lex_state_type s);
      logic [5:0]  k;
      logic [63:0] mask;
      k = K_ID;
      mask = ~64'd0 << {(4'd8 - s.wlen), 3'd0};
      if (s.wlen <= 4'(KEYWORD_BYTES)) begin
         for (int i = 15; i >= 0; i--) begin
            if (KW_LEN[i] == s.wlen && ((s.prefix ^ KW_TEXT[i]) & mask) == 64'd0) begin
               k = 6'(i);
            end
         end
      end
      return k;
   endfunction

   function automatic step_out_type lex_step(input lex_state_type s, input logic [7:0] c,
                                             input logic [15:0] pos, input logic [15:0] nxt);
      step_out_type r;
      logic [5:0]   pk;
      logic [5:0]   ok;
      logic [15:0]  bang;
      r = '0;
      r.st = s;
      pk = punct_kind(c);
      ok = op_kind(s.held, c);
      bang = (s.held != 8'd0) ? 16'(POS_LIMIT) : ((pos != 16'd0) ? pos - 16'd1 : 16'd0);
      case (s.mode)
         M_IDLE: begin
            if (!is_space(c)) begin
               r.st.tstart = pos;
               if (is_alpha(c)) begin
                  r.st.mode = M_IDENT;
                  r.st.prefix[7] = c;
                  r.st.wlen = 4'd1;
               end else if (is_digit(c)) begin
                  r.st.mode = M_NUMBER;
               end else if (is_holdable(c)) begin
                  r.st.mode = M_HELD;
                  r.st.held = c;
               end else if (pk != K_NONE) begin
                  r.n = 2'd1;
                  r.tok0 = '{pk, pos, nxt, 1'b0};
               end else begin
                  r.st.mode = M_ERROR;
               end
            end
         end
         M_IDENT: begin
            if (is_alpha(c) || is_digit(c) || c == "_") begin
               if (s.wlen < 4'(KEYWORD_BYTES)) r.st.prefix[3'(4'd7 - s.wlen)] = c;
               if (s.wlen <= 4'(KEYWORD_BYTES)) r.st.wlen = s.wlen + 4'd1;
            end else begin
               r.n = 2'd1;
               r.tok0 = '{word_kind(s), s.tstart, pos, 1'b0};
               r.st.mode = M_IDLE;
               r.redo = 1'b1;
            end
         end
         M_NUMBER: begin
            if (!is_digit(c)) begin
               r.n = 2'd1;
               r.tok0 = '{K_NUM, s.tstart, pos, 1'b0};
               r.st.mode = M_IDLE;
               r.redo = 1'b1;
            end
         end
         M_HELD: begin
            if (s.held == "/" && c == "/") begin
               r.st.mode = M_LINE;
            end else if (s.held == "/" && c == "*") begin
               r.st.mode = M_BLOCK;
            end else if (ok != K_NONE) begin
               r.n = 2'd1;
               r.tok0 = '{ok, s.tstart, nxt, 1'b0};
               r.st.mode = M_IDLE;
            end else if (s.held == "!") begin
               r.st.mode = M_ERROR;
               r.redo = 1'b1;
            end else begin
               r.n = 2'd1;
               r.tok0 = '{(punct_kind(s.held) != K_NONE) ? punct_kind(s.held) : K_ERROR,
                          s.tstart, pos, 1'b0};
               r.st.mode = M_IDLE;
               r.redo = 1'b1;
            end
         end
         M_ERROR: begin
            if (is_alpha(c) || is_digit(c) || pk != K_NONE) begin
               r.n = 2'd1;
               r.tok0 = '{K_ERROR, s.tstart, pos, 1'b0};
               r.st.mode = M_IDLE;
               r.redo = 1'b1;
            end else if (c == "!") begin
               r.st.mode = M_ERRBANG;
               r.st.held = (pos == 16'(POS_LIMIT)) ? 8'd1 : 8'd0;
            end
         end
         M_ERRBANG: begin
            if (c == "=") begin
               r.n = 2'd2;
               r.tok0 = '{K_ERROR, s.tstart, bang, 1'b0};
               r.tok1 = '{K_OP_NE, bang, nxt, 1'b0};
               r.st.mode = M_IDLE;
            end else begin
               r.st.mode = M_ERROR;
               r.redo = 1'b1;
            end
         end
         M_LINE: begin
            if (c == 8'h0a) r.st.mode = M_IDLE;
         end
         M_BLOCK: begin
            if (c == "*") r.st.mode = M_BLOCKSTAR;
         end
         M_BLOCKSTAR: begin
            if (c == "/") r.st.mode = M_IDLE;
            else if (c != "*") r.st.mode = M_BLOCK;
         end
         default: begin
            r.st.mode = M_IDLE;
            r.redo = 1'b1;
         end
      endcase
      return r;
   endfunction

endpackage

### rtl/core/kwl_front.sv
// front end: scan state, per-byte classification and token bundle building
module kwl_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kwl_pkg::req_word_type req_word,
   output logic                  push_valid,
   input  logic                  push_ready,
   output kwl_pkg::bundle_type   push_bundle
);

   kwl_pkg::lex_state_type state_ff, state_in;
   logic [15:0]            pos_ff, pos_in;
   kwl_pkg::step_out_type  s1, s2, s3;
   kwl_pkg::lex_state_type fs;
   kwl_pkg::rsp_word_type  cand [6];
   logic [5:0]             cand_v;
   logic [15:0]            nxt;
   logic [5:0]             hk;
   logic [1:0]             cnt;
   logic                   fire;

   assign req_ready = push_ready;
   assign fire = req_valid && push_ready;
   assign nxt = (pos_ff < 16'(kwl_pkg::POS_LIMIT)) ? pos_ff + 16'd1 : 16'(kwl_pkg::POS_LIMIT);

   always_comb begin
      s1 = kwl_pkg::lex_step(state_ff, req_word.char_code, pos_ff, nxt);
      s2 = kwl_pkg::lex_step(s1.st, req_word.char_code, pos_ff, nxt);
      s3 = kwl_pkg::lex_step(s2.st, req_word.char_code, pos_ff, nxt);
      if (!s1.redo) fs = s1.st;
      else if (!s2.redo) fs = s2.st;
      else fs = s3.st;
      hk = kwl_pkg::punct_kind(fs.held);

      cand[0] = s1.tok0;
      cand[1] = s1.tok1;
      cand[2] = s2.tok0;
      cand[3] = s3.tok0;
      cand[4] = '0;
      cand[5] = '{kwl_pkg::K_END, nxt, nxt, 1'b1};
      cand_v[0] = s1.n != 2'd0;
      cand_v[1] = s1.n == 2'd2;
      cand_v[2] = s1.redo && s2.n != 2'd0;
      cand_v[3] = s1.redo && s2.redo && s3.n != 2'd0;
      cand_v[4] = 1'b0;
      cand_v[5] = req_word.is_last;
      if (req_word.is_last) begin
         case (fs.mode)
            kwl_pkg::M_IDENT: begin
               cand_v[4] = 1'b1;
               cand[4] = '{kwl_pkg::word_kind(fs), fs.tstart, nxt, 1'b0};
            end
            kwl_pkg::M_NUMBER: begin
               cand_v[4] = 1'b1;
               cand[4] = '{kwl_pkg::K_NUM, fs.tstart, nxt, 1'b0};
            end
            kwl_pkg::M_HELD: begin
               cand_v[4] = 1'b1;
               cand[4] = '{(fs.held == "!" || hk == kwl_pkg::K_NONE) ? kwl_pkg::K_ERROR : hk,
                           fs.tstart, nxt, 1'b0};
            end
            kwl_pkg::M_ERROR, kwl_pkg::M_ERRBANG, kwl_pkg::M_LINE, kwl_pkg::M_BLOCK,
            kwl_pkg::M_BLOCKSTAR: begin
               cand_v[4] = 1'b1;
               cand[4] = '{kwl_pkg::K_ERROR, fs.tstart, nxt, 1'b0};
            end
            default: cand_v[4] = 1'b0;
         endcase
      end

      push_bundle = '0;
      cnt = 2'd0;
      for (int i = 0; i < 6; i++) begin
         if (cand_v[i] && cnt != 2'(kwl_pkg::MAX_TOKENS)) begin
            push_bundle.tok[cnt] = cand[i];
            cnt = cnt + 2'd1;
         end
      end
      push_bundle.count = cnt;
      push_valid = req_valid && cnt != 2'd0;

      state_in = state_ff;
      pos_in = pos_ff;
      if (fire) begin
         if (req_word.is_last) begin
            state_in = fs;
            state_in.mode = kwl_pkg::M_IDLE;
            state_in.tstart = '0;
            state_in.wlen = '0;
            state_in.held = '0;
            pos_in = '0;
         end else begin
            state_in = fs;
            pos_in = nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      state_ff.prefix <= state_in.prefix;
      if (reset) begin
         state_ff.mode <= kwl_pkg::M_IDLE;
         state_ff.tstart <= '0;
         state_ff.wlen <= '0;
         state_ff.held <= '0;
         pos_ff <= '0;
      end else begin
         state_ff.mode <= state_in.mode;
         state_ff.tstart <= state_in.tstart;
         state_ff.wlen <= state_in.wlen;
         state_ff.held <= state_in.held;
         pos_ff <= pos_in;
      end
   end

endmodule

### rtl/core/kwl_queue.sv
// short bundle queue between the front and back ends
module kwl_queue #(
   parameter int DEPTH = kwl_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                not_full,
   input  kwl_pkg::bundle_type push_data,
   output logic                not_empty,
   input  logic                pop,
   output kwl_pkg::bundle_type head
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   kwl_pkg::bundle_type mem_ff [DEPTH];
   logic [AW-1:0]       wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]       cnt_ff, cnt_in;

   assign not_full = cnt_ff != CW'(DEPTH);
   assign not_empty = cnt_ff != '0;
   assign head = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      if (pop) rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      if (push && !pop) cnt_in = cnt_ff + CW'(1);
      else if (pop && !push) cnt_in = cnt_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### rtl/core/kwl_back.sv
// back end: hands out the tokens of each bundle one word at a time
module kwl_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  kwl_pkg::bundle_type   head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kwl_pkg::rsp_word_type rsp_word
);

   logic [1:0] idx_ff, idx_in;
   logic       last_tok;

   assign rsp_valid = head_valid;
   assign rsp_word = head.tok[idx_ff];
   assign last_tok = idx_ff == head.count - 2'd1;
   assign pop = rsp_valid && rsp_ready && last_tok;

   always_comb begin
      idx_in = idx_ff;
      if (rsp_valid && rsp_ready) idx_in = last_tok ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

### rtl/core/keyword_token_lexer_core.sv
// top level of the keyword token lexer
// usage:
//   req channel takes one source byte per word (char_code, is_last)
//   rsp channel returns tokens (token_kind, start_pos, end_pos, final_item)
//   a byte yields zero to three tokens; the last byte of a text flushes any
//   pending token and adds an end word with final_item set
// timing:
//   a byte is scanned in the cycle it is accepted; its tokens are registered in
//   the bundle queue and reach rsp from its head; one byte per cycle while each
//   byte yields at most one token and rsp_ready is high; rsp delivers one token
//   per cycle, so bursts of tokens slow the input to that rate
//   the bundle queue depth sets how many scanned bytes may wait
// reset: scan state goes to between tokens, offsets to zero, queue empties
// stall: when rsp_ready is low tokens wait in the queue; once it is full
//   req_ready drops, and no token is lost or repeated
module keyword_token_lexer_core #(
   parameter int QUEUE_DEPTH = kwl_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kwl_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output kwl_pkg::rsp_word_type rsp_word
);

   logic                push_valid, push_ready, head_valid, pop;
   kwl_pkg::bundle_type push_bundle, head;

   kwl_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .push_valid(push_valid), .push_ready(push_ready), .push_bundle(push_bundle)
   );

   kwl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .push(push_valid && push_ready), .not_full(push_ready), .push_data(push_bundle),
      .not_empty(head_valid), .pop(pop), .head(head)
   );

   kwl_back u_back (
      .clock(clock), .reset(reset),
      .head_valid(head_valid), .head(head), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );

endmodule

### sim/testbench.sv
// testbench for the keyword token lexer: directed and random texts checked against a token predictor
`timescale 1ns / 100ps

module testbench;

   localparam int LIMIT_CYCLES = 200000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   kwl_pkg::req_word_type req_word;
   logic rsp_valid;
   logic rsp_ready;
   kwl_pkg::rsp_word_type rsp_word;

   keyword_token_lexer_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // predictor state
   typedef enum int {
      S_IDLE, S_IDENT, S_NUMBER, S_HELD, S_ERROR, S_ERRBANG, S_LINE, S_BLOCK, S_BLOCKSTAR
   } lex_mode_type;

   lex_mode_type lx_mode;
   int unsigned lx_start;
   int unsigned lx_pos;
   logic [7:0] lx_word [8];
   int unsigned lx_len;
   logic [7:0] lx_held;

   kwl_pkg::rsp_word_type token_queue [$];
   int errors;
   int cycles;

   string kw_names [16] = '{"int", "struct", "nil", "break", "continue", "return", "if",
      "else", "while", "new", "let", "extern", "fn", "and", "or", "not"};
   string punct_chars = ":;,&+-*/<>.=()[]{}?";

   function automatic int char_punct(logic [7:0] c);
      for (int i = 0; i < 19; i++)
         if (punct_chars[i] == c) return int'(kwl_pkg::K_PUNCT) + i;
      return -1;
   endfunction

   function automatic int char_op(logic [7:0] a, logic [7:0] b);
      if (b == "=") begin
         if (a == "!") return int'(kwl_pkg::K_OP_NE);
         if (a == "<") return int'(kwl_pkg::K_OP_LE);
         if (a == ">") return int'(kwl_pkg::K_OP_GE);
         if (a == "=") return int'(kwl_pkg::K_OP_EQ);
      end
      if (a == "-" && b == ">") return int'(kwl_pkg::K_OP_ARROW);
      return -1;
   endfunction

   function automatic bit letter(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic bit digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit blank(logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic int ident_kind();
      bit same;
      if (lx_len > 8) return int'(kwl_pkg::K_ID);
      for (int k = 0; k < 16; k++) begin
         if (kw_names[k].len() == lx_len) begin
            same = 1;
            for (int i = 0; i < lx_len; i++)
               if (kw_names[k][i] != lx_word[i]) same = 0;
            if (same) return k;
         end
      end
      return int'(kwl_pkg::K_ID);
   endfunction

   task automatic push_token(int kind, int unsigned s, int unsigned e, bit fin);
      kwl_pkg::rsp_word_type t;
      t.token_kind = 6'(kind);
      t.start_pos = 16'(s);
      t.end_pos = 16'(e);
      t.final_item = fin;
      token_queue = {token_queue, t};
   endtask

   task automatic clear_lexer();
      lx_mode = S_IDLE;
      lx_start = 0;
      lx_pos = 0;
      lx_len = 0;
      lx_held = 0;
      foreach (lx_word[i]) lx_word[i] = 0;
   endtask

   task automatic predict_byte(logic [7:0] c, bit last);
      int unsigned p;
      int unsigned nx;
      int unsigned bang;
      bit redo;
      int k;
      p = lx_pos;
      nx = (p < kwl_pkg::POS_LIMIT) ? p + 1 : kwl_pkg::POS_LIMIT;
      redo = 1;
      while (redo) begin
         redo = 0;
         case (lx_mode)
            S_IDLE: begin
               if (!blank(c)) begin
                  lx_start = p;
                  k = char_punct(c);
                  if (letter(c)) begin
                     lx_mode = S_IDENT;
                     lx_word[0] = c;
                     lx_len = 1;
                  end else if (digit(c)) begin
                     lx_mode = S_NUMBER;
                  end else if (c == "!" || c == "<" || c == ">" || c == "-" || c == "="
                               || c == "/") begin
                     lx_mode = S_HELD;
                     lx_held = c;
                  end else if (k >= 0) begin
                     push_token(k, p, nx, 0);
                  end else begin
                     lx_mode = S_ERROR;
                  end
               end
            end
            S_IDENT: begin
               if (letter(c) || digit(c) || c == "_") begin
                  if (lx_len < 8) lx_word[lx_len] = c;
                  if (lx_len <= 8) lx_len++;
               end else begin
                  push_token(ident_kind(), lx_start, p, 0);
                  lx_mode = S_IDLE;
                  redo = 1;
               end
            end
            S_NUMBER: begin
               if (!digit(c)) begin
                  push_token(int'(kwl_pkg::K_NUM), lx_start, p, 0);
                  lx_mode = S_IDLE;
                  redo = 1;
               end
            end
            S_HELD: begin
               k = char_op(lx_held, c);
               if (lx_held == "/" && c == "/") lx_mode = S_LINE;
               else if (lx_held == "/" && c == "*") lx_mode = S_BLOCK;
               else if (k >= 0) begin
                  push_token(k, lx_start, nx, 0);
                  lx_mode = S_IDLE;
               end else if (lx_held == "!") begin
                  lx_mode = S_ERROR;
                  redo = 1;
               end else begin
                  k = char_punct(lx_held);
                  push_token(k >= 0 ? k : int'(kwl_pkg::K_ERROR), lx_start, p, 0);
                  lx_mode = S_IDLE;
                  redo = 1;
               end
            end
            S_ERROR: begin
               if (letter(c) || digit(c) || char_punct(c) >= 0) begin
                  push_token(int'(kwl_pkg::K_ERROR), lx_start, p, 0);
                  lx_mode = S_IDLE;
                  redo = 1;
               end else if (c == "!") begin
                  lx_mode = S_ERRBANG;
                  lx_held = (p == kwl_pkg::POS_LIMIT) ? 8'd1 : 8'd0;
               end
            end
            S_ERRBANG: begin
               if (c == "=") begin
                  bang = (lx_held != 0) ? kwl_pkg::POS_LIMIT : ((p != 0) ? p - 1 : 0);
                  push_token(int'(kwl_pkg::K_ERROR), lx_start, bang, 0);
                  push_token(int'(kwl_pkg::K_OP_NE), bang, nx, 0);
                  lx_mode = S_IDLE;
               end else begin
                  lx_mode = S_ERROR;
                  redo = 1;
               end
            end
            S_LINE: if (c == 8'h0a) lx_mode = S_IDLE;
            S_BLOCK: if (c == "*") lx_mode = S_BLOCKSTAR;
            S_BLOCKSTAR: begin
               if (c == "/") lx_mode = S_IDLE;
               else if (c != "*") lx_mode = S_BLOCK;
            end
            default: begin
               lx_mode = S_IDLE;
               redo = 1;
            end
         endcase
      end
      lx_pos = nx;
      if (last) begin
         case (lx_mode)
            S_IDENT: push_token(ident_kind(), lx_start, nx, 0);
            S_NUMBER: push_token(int'(kwl_pkg::K_NUM), lx_start, nx, 0);
            S_HELD: begin
               k = char_punct(lx_held);
               push_token((lx_held == "!" || k < 0) ? int'(kwl_pkg::K_ERROR) : k,
                          lx_start, nx, 0);
            end
            S_IDLE: ;
            default: push_token(int'(kwl_pkg::K_ERROR), lx_start, nx, 0);
         endcase
         push_token(int'(kwl_pkg::K_END), nx, nx, 1);
         clear_lexer();
      end
   endtask

   // sender bursts
   int burst_left;

   task automatic send_byte(logic [7:0] c, bit last);
      while (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(1, 20);
         else begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_word <= '{char_code: c, is_last: last};
      predict_byte(c, last);
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (token_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // receiver stall pattern
   int stall_phase;
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (reset) rsp_ready <= 1'b0;
      else if (stall_phase[7:6] == 2'd0) rsp_ready <= 1'b1;
      else rsp_ready <= ((stall_phase % 5) != 0) && ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      kwl_pkg::rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (token_queue.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected token %p", rsp_word);
         end else begin
            want = token_queue.pop_front();
            if (rsp_word !== want) begin
               errors++;
               if (errors <= 10) $display("mismatch expected %p actual %p", want, rsp_word);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic test_keywords();
      send_text("int struct nil break continue return if else while new let extern");
      send_text("fn and or not continues Zz_9");
   endtask

   task automatic test_operators();
      send_text("!=<=>=->==:;,&+-*/<>.=()[]{}? 0123 9");
   endtask

   task automatic test_special();
      send_text("a!b $ !=@ !");
      send_text("x//n\ny/*a**/z");
      send_text("q//o");
      send_text("//\n");
      send_text("/*/o");
      send_byte(8'hff, 1);
      send_byte(8'h00, 1);
   endtask

   function automatic logic [7:0] pick_byte();
      string frag = "aeintxz_AZ09!=<>-/*;(}.? \n\t$~#";
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
      return frag[$urandom_range(0, frag.len() - 1)];
   endfunction

   task automatic test_random();
      int n;
      for (int t = 0; t < 4; t++) begin
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++)
            send_byte(pick_byte(), (i == n - 1) && ($urandom_range(0, 4) != 0));
         if (t == 2) wait_drained();
      end
      send_byte(" ", 1);
   endtask

   initial begin
      errors = 0;
      cycles = 0;
      stall_phase = 0;
      burst_left = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      clear_lexer();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_keywords();
      test_operators();
      test_special();
      test_random();
      wait_drained();
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
